// ----- rtl/lavm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared widths, types and pipeline depths of the look-at view matrix unit.
// ----------------------------------------------------------------------------
package lavm_pkg;

	localparam int CoordWidth = 32;
	localparam int WideWidth  = 64;
	localparam int SqrtSteps  = 32;
	localparam int DivSteps   = 31;
	// Front stages, square root, dividend setup, division, sign stage.
	localparam int NormLatency = 7 + SqrtSteps + 1 + DivSteps + 1;

	typedef logic signed [CoordWidth-1:0] coord_t;
	typedef logic signed [WideWidth-1:0]  wide_t;

endpackage

// ----- rtl/lavm_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_norm
// Pipelined 3-vector normalizer: scales the components so the largest lies
// in [2^30, 2^31), takes the integer square root of the sum of squares and
// divides each component by it with rounding. Result in signed Q1.30.
// ----------------------------------------------------------------------------
module lavm_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  lavm_pkg::wide_t in_vec [3],
	output logic            out_valid,
	output lavm_pkg::coord_t out_vec [3]
);

	localparam int Ss = lavm_pkg::SqrtSteps;
	localparam int Ds = lavm_pkg::DivSteps;

	// Front stages.
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [63:0] mag_s1 [3];
	logic [63:0] mag_s2 [3];
	logic [63:0] mag_s3 [3];
	logic [63:0] mag_s4 [3];
	logic [2:0]  neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [63:0] or_s2;
	logic [3:0]  nz_s3;
	logic [3:0]  cpos_s3 [4];
	logic [5:0]  pos_s4;
	logic        zero_s4, zero_s5, zero_s6;
	logic [30:0] mag_s5 [3];
	logic [30:0] mag_s6 [3];
	logic [61:0] sq_s6 [3];

	// Square root iterations; index 0 is the stage that holds the sum.
	logic        sr_v    [Ss+1];
	logic [63:0] sr_sum  [Ss+1];
	logic [31:0] sr_root [Ss+1];
	logic [33:0] sr_rem  [Ss+1];
	logic [30:0] sr_mag  [Ss+1][3];
	logic [2:0]  sr_neg  [Ss+1];
	logic        sr_zero [Ss+1];
	logic [31:0] sr_root_nx [Ss];
	logic [33:0] sr_rem_nx  [Ss];

	// Division iterations; index 0 is the dividend setup stage.
	logic        dv_v    [Ds+1];
	logic [31:0] dv_n    [Ds+1];
	logic [31:0] dv_rem  [Ds+1][3];
	logic [30:0] dv_low  [Ds+1][3];
	logic [30:0] dv_quo  [Ds+1][3];
	logic [2:0]  dv_neg  [Ds+1];
	logic        dv_zero [Ds+1];
	logic [31:0] dv_rem_nx [Ds][3];
	logic        dv_bit_nx [Ds][3];

	logic [3:0]  cpos_c [4];
	logic [5:0]  pos_c;
	logic [61:0] dvd_c [3];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			cpos_c[c] = '0;
			for (int b = 0; b < 16; b++) begin
				if (or_s2[16*c+b]) cpos_c[c] = 4'(b);
			end
		end
		pos_c = '0;
		for (int c = 0; c < 4; c++) begin
			if (nz_s3[c]) pos_c = {2'(c), cpos_s3[c]};
		end
	end

	// One root bit per stage, two radicand bits brought in each time.
	always_comb begin
		logic [35:0] cur;
		logic [35:0] trial;
		for (int k = 0; k < Ss; k++) begin
			cur   = {sr_rem[k], sr_sum[k][63-2*k -: 2]};
			trial = {2'b00, sr_root[k], 2'b01};
			if (cur >= trial) begin
				sr_rem_nx[k]  = 34'(cur - trial);
				sr_root_nx[k] = {sr_root[k][30:0], 1'b1};
			end else begin
				sr_rem_nx[k]  = 34'(cur);
				sr_root_nx[k] = {sr_root[k][30:0], 1'b0};
			end
		end
	end

	// The dividend is the magnitude times 2^30, plus half the root for rounding.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dvd_c[i] = {1'b0, sr_mag[Ss][i], 30'b0} + 62'(sr_root[Ss] >> 1);
		end
	end

	// Restoring division, one quotient bit per stage.
	always_comb begin
		logic [32:0] r;
		for (int j = 0; j < Ds; j++) begin
			for (int i = 0; i < 3; i++) begin
				r = {dv_rem[j][i], dv_low[j][i][Ds-1-j]};
				if (r >= {1'b0, dv_n[j]}) begin
					dv_rem_nx[j][i] = 32'(r - {1'b0, dv_n[j]});
					dv_bit_nx[j][i] = 1'b1;
				end else begin
					dv_rem_nx[j][i] = r[31:0];
					dv_bit_nx[j][i] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k <= Ss; k++) sr_v[k] <= 1'b0;
			for (int j = 0; j <= Ds; j++) dv_v[j] <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			sr_v[0] <= v_s6;
			for (int k = 0; k < Ss; k++) sr_v[k+1] <= sr_v[k];
			dv_v[0] <= sr_v[Ss];
			for (int j = 0; j < Ds; j++) dv_v[j+1] <= dv_v[j];
			out_valid <= dv_v[Ds];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= in_vec[i][63];
			mag_s1[i] <= in_vec[i][63] ? 64'(-in_vec[i]) : 64'(in_vec[i]);
		end
		or_s2  <= mag_s1[0] | mag_s1[1] | mag_s1[2];
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		for (int c = 0; c < 4; c++) begin
			nz_s3[c]   <= |or_s2[16*c +: 16];
			cpos_s3[c] <= cpos_c[c];
		end
		mag_s3  <= mag_s2;
		neg_s3  <= neg_s2;
		pos_s4  <= pos_c;
		zero_s4 <= ~|nz_s3;
		mag_s4  <= mag_s3;
		neg_s4  <= neg_s3;
		for (int i = 0; i < 3; i++) begin
			if (pos_s4 >= 6'd30) begin
				mag_s5[i] <= 31'(mag_s4[i] >> (pos_s4 - 6'd30));
			end else begin
				mag_s5[i] <= 31'(mag_s4[i] << (6'd30 - pos_s4));
			end
		end
		neg_s5  <= neg_s4;
		zero_s5 <= zero_s4;
		for (int i = 0; i < 3; i++) sq_s6[i] <= 62'(mag_s5[i]) * 62'(mag_s5[i]);
		mag_s6  <= mag_s5;
		neg_s6  <= neg_s5;
		zero_s6 <= zero_s5;

		sr_sum[0]  <= 64'(sq_s6[0]) + 64'(sq_s6[1]) + 64'(sq_s6[2]);
		sr_root[0] <= '0;
		sr_rem[0]  <= '0;
		sr_mag[0]  <= mag_s6;
		sr_neg[0]  <= neg_s6;
		sr_zero[0] <= zero_s6;
		for (int k = 0; k < Ss; k++) begin
			sr_sum[k+1]  <= sr_sum[k];
			sr_root[k+1] <= sr_root_nx[k];
			sr_rem[k+1]  <= sr_rem_nx[k];
			sr_mag[k+1]  <= sr_mag[k];
			sr_neg[k+1]  <= sr_neg[k];
			sr_zero[k+1] <= sr_zero[k];
		end

		dv_n[0]    <= sr_root[Ss];
		dv_neg[0]  <= sr_neg[Ss];
		dv_zero[0] <= sr_zero[Ss];
		for (int i = 0; i < 3; i++) begin
			dv_rem[0][i] <= {1'b0, dvd_c[i][61:31]};
			dv_low[0][i] <= dvd_c[i][30:0];
			dv_quo[0][i] <= '0;
		end
		for (int j = 0; j < Ds; j++) begin
			dv_n[j+1]    <= dv_n[j];
			dv_neg[j+1]  <= dv_neg[j];
			dv_zero[j+1] <= dv_zero[j];
			for (int i = 0; i < 3; i++) begin
				dv_rem[j+1][i] <= dv_rem_nx[j][i];
				dv_low[j+1][i] <= dv_low[j][i];
				dv_quo[j+1][i] <= {dv_quo[j][i][29:0], dv_bit_nx[j][i]};
			end
		end

		for (int i = 0; i < 3; i++) begin
			if (dv_zero[Ds]) begin
				out_vec[i] <= '0;
			end else if (dv_neg[Ds][i]) begin
				out_vec[i] <= -lavm_pkg::coord_t'({1'b0, dv_quo[Ds][i]});
			end else begin
				out_vec[i] <= lavm_pkg::coord_t'({1'b0, dv_quo[Ds][i]});
			end
		end
	end

endmodule

// ----- rtl/look_at_view_matrix_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Fixed-point look-at view transform: three unit axes in Q1.30 and the
// view translation in Q16.16, saturated.
// ----------------------------------------------------------------------------
// Usage: drive eye, target and up (signed Q16.16) and pulse start; a transfer
// happens on every edge with start high, since busy is held low. Each item
// gives one result: side, upward and back rows plus shift_x/y/z appear on the
// result ports for a single cycle with done high.
// Throughput is one item per clock. An item passes through the three
// normalizers in series, each with a 32-stage square root and a 31-stage
// divider, with cross product stages between them and dot product stages
// after the last one.
// Reset clears every valid bit, so no result appears until an item is
// accepted. The receiver cannot stall: results must be taken when done is
// high.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  lavm_pkg::coord_t eye_x,
	input  lavm_pkg::coord_t eye_y,
	input  lavm_pkg::coord_t eye_z,
	input  lavm_pkg::coord_t target_x,
	input  lavm_pkg::coord_t target_y,
	input  lavm_pkg::coord_t target_z,
	input  lavm_pkg::coord_t up_x,
	input  lavm_pkg::coord_t up_y,
	input  lavm_pkg::coord_t up_z,
	output logic             done,
	output lavm_pkg::coord_t side_x,
	output lavm_pkg::coord_t side_y,
	output lavm_pkg::coord_t side_z,
	output lavm_pkg::coord_t upward_x,
	output lavm_pkg::coord_t upward_y,
	output lavm_pkg::coord_t upward_z,
	output lavm_pkg::coord_t back_x,
	output lavm_pkg::coord_t back_y,
	output lavm_pkg::coord_t back_z,
	output lavm_pkg::coord_t shift_x,
	output lavm_pkg::coord_t shift_y,
	output lavm_pkg::coord_t shift_z
);

	localparam int L = lavm_pkg::NormLatency;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	lavm_pkg::coord_t eye_s1 [3];
	lavm_pkg::coord_t tgt_s1 [3];
	lavm_pkg::coord_t up_s1  [3];
	lavm_pkg::coord_t eye_s2 [3];
	lavm_pkg::coord_t up_s2  [3];
	lavm_pkg::wide_t  fwd_s2 [3];

	lavm_pkg::coord_t dla_eye [L][3];
	lavm_pkg::coord_t dla_up  [L][3];
	lavm_pkg::coord_t dlb_eye [L][3];
	lavm_pkg::coord_t dlb_back [L][3];
	lavm_pkg::coord_t dlc_eye [L][3];
	lavm_pkg::coord_t dlc_back [L][3];
	lavm_pkg::coord_t dlc_side [L][3];

	logic             n0_valid, n1_valid, n2_valid;
	lavm_pkg::coord_t back_n [3];
	lavm_pkg::coord_t side_n [3];
	lavm_pkg::coord_t upw_n  [3];

	lavm_pkg::wide_t  p1_s3 [6];
	lavm_pkg::coord_t back_s3 [3];
	lavm_pkg::coord_t eye_s3  [3];
	lavm_pkg::wide_t  sx_s4 [3];
	lavm_pkg::coord_t back_s4 [3];
	lavm_pkg::coord_t eye_s4  [3];

	lavm_pkg::wide_t  p2_s5 [6];
	lavm_pkg::coord_t side_s5 [3];
	lavm_pkg::coord_t back_s5 [3];
	lavm_pkg::coord_t eye_s5  [3];
	lavm_pkg::wide_t  ux_s6 [3];
	lavm_pkg::coord_t side_s6 [3];
	lavm_pkg::coord_t back_s6 [3];
	lavm_pkg::coord_t eye_s6  [3];

	lavm_pkg::wide_t  dp_s7 [3][3];
	lavm_pkg::coord_t row_s7 [3][3];
	lavm_pkg::wide_t  dot_s8 [3];
	lavm_pkg::coord_t row_s8 [3][3];

	lavm_pkg::coord_t shift_c [3];

	assign busy = 1'b0;

	lavm_norm u_norm_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s2), .in_vec(fwd_s2),
		.out_valid(n0_valid), .out_vec(back_n)
	);

	lavm_norm u_norm_side (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s4), .in_vec(sx_s4),
		.out_valid(n1_valid), .out_vec(side_n)
	);

	lavm_norm u_norm_upward (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s6), .in_vec(ux_s6),
		.out_valid(n2_valid), .out_vec(upw_n)
	);

	// Negate, round half away from zero to Q16.16 and saturate.
	always_comb begin
		logic signed [63:0] t;
		logic [63:0]        mag;
		logic [33:0]        q;
		for (int r = 0; r < 3; r++) begin
			t   = -dot_s8[r];
			mag = t[63] ? 64'(-t) : 64'(t);
			q   = 34'((mag + 64'd536870912) >> 30);
			if (t[63]) begin
				if (q > 34'h080000000) q = 34'h080000000;
				shift_c[r] = lavm_pkg::coord_t'(-q);
			end else begin
				if (q > 34'h07FFFFFFF) q = 34'h07FFFFFFF;
				shift_c[r] = lavm_pkg::coord_t'(q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= n0_valid;
			v_s4 <= v_s3;
			v_s5 <= n1_valid;
			v_s6 <= v_s5;
			v_s7 <= n2_valid;
			v_s8 <= v_s7;
			done <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		eye_s1 <= '{eye_x, eye_y, eye_z};
		tgt_s1 <= '{target_x, target_y, target_z};
		up_s1  <= '{up_x, up_y, up_z};
		for (int i = 0; i < 3; i++) begin
			fwd_s2[i] <= lavm_pkg::wide_t'(eye_s1[i]) - lavm_pkg::wide_t'(tgt_s1[i]);
		end
		eye_s2 <= eye_s1;
		up_s2  <= up_s1;

		// Side data rides alongside each normalizer.
		dla_eye[0] <= eye_s2;
		dla_up[0]  <= up_s2;
		dlb_eye[0] <= eye_s4;
		dlb_back[0] <= back_s4;
		dlc_eye[0] <= eye_s6;
		dlc_back[0] <= back_s6;
		dlc_side[0] <= side_s6;
		for (int k = 1; k < L; k++) begin
			dla_eye[k]  <= dla_eye[k-1];
			dla_up[k]   <= dla_up[k-1];
			dlb_eye[k]  <= dlb_eye[k-1];
			dlb_back[k] <= dlb_back[k-1];
			dlc_eye[k]  <= dlc_eye[k-1];
			dlc_back[k] <= dlc_back[k-1];
			dlc_side[k] <= dlc_side[k-1];
		end

		// side direction = up x back
		p1_s3[0] <= lavm_pkg::wide_t'(dla_up[L-1][1]) * lavm_pkg::wide_t'(back_n[2]);
		p1_s3[1] <= lavm_pkg::wide_t'(dla_up[L-1][2]) * lavm_pkg::wide_t'(back_n[1]);
		p1_s3[2] <= lavm_pkg::wide_t'(dla_up[L-1][2]) * lavm_pkg::wide_t'(back_n[0]);
		p1_s3[3] <= lavm_pkg::wide_t'(dla_up[L-1][0]) * lavm_pkg::wide_t'(back_n[2]);
		p1_s3[4] <= lavm_pkg::wide_t'(dla_up[L-1][0]) * lavm_pkg::wide_t'(back_n[1]);
		p1_s3[5] <= lavm_pkg::wide_t'(dla_up[L-1][1]) * lavm_pkg::wide_t'(back_n[0]);
		back_s3 <= back_n;
		eye_s3  <= dla_eye[L-1];
		sx_s4[0] <= p1_s3[0] - p1_s3[1];
		sx_s4[1] <= p1_s3[2] - p1_s3[3];
		sx_s4[2] <= p1_s3[4] - p1_s3[5];
		back_s4 <= back_s3;
		eye_s4  <= eye_s3;

		// upward direction = back x side
		p2_s5[0] <= lavm_pkg::wide_t'(dlb_back[L-1][1]) * lavm_pkg::wide_t'(side_n[2]);
		p2_s5[1] <= lavm_pkg::wide_t'(dlb_back[L-1][2]) * lavm_pkg::wide_t'(side_n[1]);
		p2_s5[2] <= lavm_pkg::wide_t'(dlb_back[L-1][2]) * lavm_pkg::wide_t'(side_n[0]);
		p2_s5[3] <= lavm_pkg::wide_t'(dlb_back[L-1][0]) * lavm_pkg::wide_t'(side_n[2]);
		p2_s5[4] <= lavm_pkg::wide_t'(dlb_back[L-1][0]) * lavm_pkg::wide_t'(side_n[1]);
		p2_s5[5] <= lavm_pkg::wide_t'(dlb_back[L-1][1]) * lavm_pkg::wide_t'(side_n[0]);
		side_s5 <= side_n;
		back_s5 <= dlb_back[L-1];
		eye_s5  <= dlb_eye[L-1];
		ux_s6[0] <= p2_s5[0] - p2_s5[1];
		ux_s6[1] <= p2_s5[2] - p2_s5[3];
		ux_s6[2] <= p2_s5[4] - p2_s5[5];
		side_s6 <= side_s5;
		back_s6 <= back_s5;
		eye_s6  <= eye_s5;

		// Translation: rows against the eye point.
		row_s7[0] <= dlc_side[L-1];
		row_s7[1] <= upw_n;
		row_s7[2] <= dlc_back[L-1];
		for (int i = 0; i < 3; i++) begin
			dp_s7[0][i] <= lavm_pkg::wide_t'(dlc_side[L-1][i]) *
				lavm_pkg::wide_t'(dlc_eye[L-1][i]);
			dp_s7[1][i] <= lavm_pkg::wide_t'(upw_n[i]) * lavm_pkg::wide_t'(dlc_eye[L-1][i]);
			dp_s7[2][i] <= lavm_pkg::wide_t'(dlc_back[L-1][i]) *
				lavm_pkg::wide_t'(dlc_eye[L-1][i]);
		end
		for (int r = 0; r < 3; r++) begin
			dot_s8[r] <= dp_s7[r][0] + dp_s7[r][1] + dp_s7[r][2];
		end
		row_s8 <= row_s7;

		side_x   <= row_s8[0][0];
		side_y   <= row_s8[0][1];
		side_z   <= row_s8[0][2];
		upward_x <= row_s8[1][0];
		upward_y <= row_s8[1][1];
		upward_z <= row_s8[1][2];
		back_x   <= row_s8[2][0];
		back_y   <= row_s8[2][1];
		back_z   <= row_s8[2][2];
		shift_x  <= shift_c[0];
		shift_y  <= shift_c[1];
		shift_z  <= shift_c[2];
	end

endmodule
